>>> rtl/core/drtf_pkg.sv
`timescale 1ns / 1ps

package drtf_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int DATE_W   = 23;
  localparam int RATE_IN_W = 48;
  localparam int RATE_W   = 47;
  localparam int AMT_W    = 32;
  localparam int VALUE_W  = 57;
  localparam int ENTRY_W  = RATE_W + DATE_W;

  // amounts that pass the range check fit in MUL_A_W bits
  localparam int MUL_A_W  = 26;
  localparam int MUL_B_W  = RATE_W - 16;

  localparam logic [AMT_W-1:0] AMOUNT_LIMIT = AMT_W'(1000 << 16);

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_EXACT   = 3'd1,
    ST_EARLIER = 3'd2,
    ST_DUP     = 3'd3,
    ST_NEG     = 3'd4,
    ST_FULL    = 3'd5,
    ST_RANGE   = 3'd6,
    ST_NONE    = 3'd7
  } status_code_t;

  typedef struct packed {
    logic         load;
    logic         srch_rd;
    logic         srch_upd;
    logic         rd_pos;
    logic         rd_prev;
    logic         shift_init;
    logic         shift_rd;
    logic         shift_wr;
    logic         store;
    logic         mul_lo;
    logic         mul_hi;
    logic         out_load;
    status_code_t code;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic range_bad;
    logic srch_done;
    logic hit;
    logic neg;
    logic full;
    logic pos_zero;
    logic shift_done;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/core/dated_rate_table_floor_convert.sv
`timescale 1ns / 1ps
// Channel   Direction  Word
// in_*      slave      tdata: date_key, rate_in, amount; tuser: action
// out_*     master     tdata: date_used, rate_used, value; tuser: status
//
// One word at a time; a search takes at most ceil(log2(entries + 1)) steps, 12 when full,
// each a read then a compare. A query then reads the found entry and, on an earlier date,
// the one before it, and on a match multiplies in two steps; an insert that is not rejected
// moves every entry above the insert point up by one, then stores; a range error skips the search.
// Reset clears the entry count and the controller, not the table. The next word is taken
// while a result waits in the output register; a stalled output holds the next result.

module dated_rate_table_floor_convert (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [103:0]  in_tdata,   // date_key[22:0], rate_in[70:23], amount[102:71]
  input  logic          in_tuser,   // action
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // date_used[22:0], rate_used[69:23], value[126:70]
  output logic [2:0]    out_tuser   // status
);

  drtf_pkg::cmd_t                   cmd;
  drtf_pkg::stat_t                  stat;
  drtf_pkg::status_code_t           out_code;
  logic [drtf_pkg::DATE_W-1:0]      out_date;
  logic [drtf_pkg::RATE_W-1:0]      out_rate;
  logic [drtf_pkg::VALUE_W-1:0]     out_value;

  drtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  drtf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_act    (in_tuser),
    .in_key    (in_tdata[22:0]),
    .in_rate   (in_tdata[70:23]),
    .in_amt    (in_tdata[102:71]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_code  (out_code),
    .out_date  (out_date),
    .out_rate  (out_rate),
    .out_value (out_value)
  );

  assign out_tuser = out_code;
  assign out_tdata = {1'b0, out_value, out_rate, out_date};

  // one word in flight: no second word taken right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in flight");

  // rejected or unmatched words carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == drtf_pkg::ST_DUP || out_tuser == drtf_pkg::ST_NEG ||
                   out_tuser == drtf_pkg::ST_FULL || out_tuser == drtf_pkg::ST_RANGE ||
                   out_tuser == drtf_pkg::ST_NONE) |-> out_tdata == '0)
    else $error("error status with nonzero payload");

  // a stored entry reports no converted value
  a_store_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == drtf_pkg::ST_STORED |-> out_tdata[126:70] == '0)
    else $error("store result with nonzero value");

  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> !$rose(out_tvalid) && $stable(out_tdata))
    else $error("output register overwritten while stalled");

endmodule

>>> rtl/core/drtf_dp.sv
`timescale 1ns / 1ps

module drtf_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  drtf_pkg::cmd_t                  cmd,
  output drtf_pkg::stat_t                 stat,
  input  logic                            in_act,
  input  logic [drtf_pkg::DATE_W-1:0]     in_key,
  input  logic [drtf_pkg::RATE_IN_W-1:0]  in_rate,
  input  logic [drtf_pkg::AMT_W-1:0]      in_amt,
  input  logic                            out_ready,
  output logic                            out_valid,
  output drtf_pkg::status_code_t          out_code,
  output logic [drtf_pkg::DATE_W-1:0]     out_date,
  output logic [drtf_pkg::RATE_W-1:0]     out_rate,
  output logic [drtf_pkg::VALUE_W-1:0]    out_value
);

  logic [drtf_pkg::ENTRY_W-1:0] mem [drtf_pkg::TABLE_DEPTH];

  logic                            act_r;
  logic [drtf_pkg::DATE_W-1:0]     key_r;
  logic [drtf_pkg::RATE_IN_W-1:0]  rate_r;
  logic [drtf_pkg::AMT_W-1:0]      amt_r;
  logic [drtf_pkg::CNT_W-1:0]      lo_r;
  logic [drtf_pkg::CNT_W-1:0]      hi_r;
  logic [drtf_pkg::CNT_W-1:0]      sh_r;
  logic [drtf_pkg::CNT_W-1:0]      count_r;
  logic [drtf_pkg::ENTRY_W-1:0]    rd_r;
  logic [drtf_pkg::VALUE_W-1:0]    prod_r;

  logic                            out_valid_r;
  drtf_pkg::status_code_t          out_code_r;
  logic [drtf_pkg::DATE_W-1:0]     out_date_r;
  logic [drtf_pkg::RATE_W-1:0]     out_rate_r;
  logic [drtf_pkg::VALUE_W-1:0]    out_value_r;

  logic [drtf_pkg::CNT_W-1:0]      mid;
  logic [drtf_pkg::CNT_W-1:0]      lo_m1;
  logic [drtf_pkg::CNT_W-1:0]      sh_m1;
  logic [drtf_pkg::IDX_W-1:0]      rd_addr;
  logic                            rd_en;
  logic [drtf_pkg::DATE_W-1:0]     rd_date;
  logic [drtf_pkg::RATE_W-1:0]     rd_rate;
  logic [drtf_pkg::MUL_B_W-1:0]    mul_b;
  logic [drtf_pkg::VALUE_W-1:0]    mul_p;

  assign rd_date = rd_r[drtf_pkg::DATE_W-1:0];
  assign rd_rate = rd_r[drtf_pkg::ENTRY_W-1:drtf_pkg::DATE_W];

  always_comb begin
    mid   = lo_r + ((hi_r - lo_r) >> 1);
    lo_m1 = lo_r - drtf_pkg::CNT_W'(1);
    sh_m1 = sh_r - drtf_pkg::CNT_W'(1);
    rd_en = cmd.srch_rd | cmd.rd_pos | cmd.rd_prev | cmd.shift_rd;
    if (cmd.srch_rd) begin
      rd_addr = mid[drtf_pkg::IDX_W-1:0];
    end else if (cmd.rd_prev) begin
      rd_addr = lo_m1[drtf_pkg::IDX_W-1:0];
    end else if (cmd.shift_rd) begin
      rd_addr = sh_m1[drtf_pkg::IDX_W-1:0];
    end else begin
      rd_addr = lo_r[drtf_pkg::IDX_W-1:0];
    end
  end

  // one shared multiplier: low 16 rate bits first, then the upper rate bits
  always_comb begin
    if (cmd.mul_hi) begin
      mul_b = rd_rate[drtf_pkg::RATE_W-1:16];
    end else begin
      mul_b = {{(drtf_pkg::MUL_B_W-16){1'b0}}, rd_rate[15:0]};
    end
    mul_p = {{(drtf_pkg::VALUE_W-drtf_pkg::MUL_A_W){1'b0}}, amt_r[drtf_pkg::MUL_A_W-1:0]}
          * {{(drtf_pkg::VALUE_W-drtf_pkg::MUL_B_W){1'b0}}, mul_b};
  end

  always_comb begin
    stat.act        = act_r;
    stat.range_bad  = amt_r[drtf_pkg::AMT_W-1] || (amt_r > drtf_pkg::AMOUNT_LIMIT);
    stat.srch_done  = (lo_r >= hi_r);
    stat.hit        = (lo_r < count_r) && (rd_date == key_r);
    stat.neg        = rate_r[drtf_pkg::RATE_IN_W-1];
    stat.full       = (count_r == drtf_pkg::CNT_W'(drtf_pkg::TABLE_DEPTH));
    stat.pos_zero   = (lo_r == '0);
    stat.shift_done = (sh_r == lo_r);
    stat.out_busy   = out_valid_r && !out_ready;
  end

  // table memory: one read or one write a cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
    if (cmd.shift_wr) begin
      mem[sh_r[drtf_pkg::IDX_W-1:0]] <= rd_r;
    end else if (cmd.store) begin
      mem[lo_r[drtf_pkg::IDX_W-1:0]] <= {rate_r[drtf_pkg::RATE_W-1:0], key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store) begin
        count_r <= count_r + drtf_pkg::CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_act;
      key_r  <= in_key;
      rate_r <= in_rate;
      amt_r  <= in_amt;
      lo_r   <= '0;
      hi_r   <= count_r;
    end else if (cmd.srch_upd) begin
      if (rd_date < key_r) begin
        lo_r <= mid + drtf_pkg::CNT_W'(1);
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.shift_init) begin
      sh_r <= count_r;
    end else if (cmd.shift_wr) begin
      sh_r <= sh_m1;
    end
    if (cmd.mul_lo) begin
      prod_r <= {16'd0, mul_p[drtf_pkg::VALUE_W-1:16]};
    end else if (cmd.mul_hi) begin
      prod_r <= prod_r + mul_p;
    end
    if (cmd.out_load) begin
      out_code_r <= cmd.code;
      case (cmd.code) inside
        drtf_pkg::ST_STORED: begin
          out_date_r  <= key_r;
          out_rate_r  <= rate_r[drtf_pkg::RATE_W-1:0];
          out_value_r <= '0;
        end
        drtf_pkg::ST_EXACT, drtf_pkg::ST_EARLIER: begin
          out_date_r  <= rd_date;
          out_rate_r  <= rd_rate;
          out_value_r <= prod_r;
        end
        default: begin
          out_date_r  <= '0;
          out_rate_r  <= '0;
          out_value_r <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_date  = out_date_r;
  assign out_rate  = out_rate_r;
  assign out_value = out_value_r;

endmodule

>>> rtl/core/drtf_ctrl.sv
`timescale 1ns / 1ps

module drtf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  drtf_pkg::stat_t stat,
  output drtf_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_POS_RD,
    S_CHECK,
    S_PREV_RD,
    S_MUL_LO,
    S_MUL_HI,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_STORE,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  drtf_pkg::status_code_t code_r, code_nxt;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (stat.act && stat.range_bad) begin
          code_nxt  = drtf_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else if (stat.srch_done) begin
          state_nxt = S_POS_RD;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRCH_RD;
      end
      S_POS_RD: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.act) begin
          if (stat.hit) begin
            code_nxt  = drtf_pkg::ST_DUP;
            state_nxt = S_DONE;
          end else if (stat.neg) begin
            code_nxt  = drtf_pkg::ST_NEG;
            state_nxt = S_DONE;
          end else if (stat.full) begin
            code_nxt  = drtf_pkg::ST_FULL;
            state_nxt = S_DONE;
          end else begin
            cmd.shift_init = 1'b1;
            state_nxt      = S_SHIFT_RD;
          end
        end else if (stat.hit) begin
          code_nxt  = drtf_pkg::ST_EXACT;
          state_nxt = S_MUL_LO;
        end else if (!stat.pos_zero) begin
          code_nxt  = drtf_pkg::ST_EARLIER;
          state_nxt = S_PREV_RD;
        end else begin
          code_nxt  = drtf_pkg::ST_NONE;
          state_nxt = S_DONE;
        end
      end
      S_PREV_RD: begin
        cmd.rd_prev = 1'b1;
        state_nxt   = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_DONE;
      end
      // move entries above the insert point up by one, top first
      S_SHIFT_RD: begin
        if (stat.shift_done) begin
          state_nxt = S_STORE;
        end else begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        code_nxt  = drtf_pkg::ST_STORED;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= drtf_pkg::ST_NONE;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

>>> verif/dated_rate_table_floor_convert_tb.sv
`timescale 1ns / 1ps

module dated_rate_table_floor_convert_tb;

  localparam int RANDOM_WORDS   = 1700;
  localparam int HOLDOFF_CYCLES = 400;
  // the timeout lies far beyond the slowest run here
  localparam int LIMIT_CYCLES   = 4_000_000;
  localparam logic [drtf_pkg::RATE_IN_W-1:0] RATE_ONE = 48'h1_0000;
  localparam logic [drtf_pkg::RATE_IN_W-1:0] RATE_MAX = 48'h7FFF_FFFF_FFFF;
  // inserts below this key come from the random part; the fill phase goes above it
  localparam int FILL_BASE      = 6_000_000;

  typedef struct {
    drtf_pkg::status_code_t          status;
    logic [drtf_pkg::DATE_W-1:0]     date;
    logic [drtf_pkg::RATE_W-1:0]     rate;
    logic [drtf_pkg::VALUE_W-1:0]    value;
  } rate_reply_t;

  class rate_table_model;
    bit [drtf_pkg::DATE_W-1:0] dates[$];
    bit [drtf_pkg::RATE_W-1:0] rates[$];
    rate_reply_t               pending_replies[$];
    int                        errors;
    int                        replies_seen;
    int                        words_logged;
    int                        status_seen[8];

    function int unsigned first_not_below(bit [drtf_pkg::DATE_W-1:0] key);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = dates.size();
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (dates[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function bit [drtf_pkg::DATE_W-1:0] known_date();
      if (dates.size() == 0) return drtf_pkg::DATE_W'($urandom);
      return dates[$urandom_range(0, dates.size() - 1)];
    endfunction

    // apply one accepted word to the table copy and queue its reply
    function void log_request(bit act, bit [drtf_pkg::DATE_W-1:0] key,
                              bit [drtf_pkg::RATE_IN_W-1:0] rate_in,
                              bit [drtf_pkg::AMT_W-1:0] amt);
      rate_reply_t r;
      int unsigned pos, idx;
      bit          hit;
      bit [72:0]   prod;
      pos = first_not_below(key);
      hit = (pos < dates.size()) && (dates[pos] == key);
      r.status = drtf_pkg::ST_STORED;
      r.date   = '0;
      r.rate   = '0;
      r.value  = '0;
      if (!act) begin
        if (hit) r.status = drtf_pkg::ST_DUP;
        else if (rate_in[drtf_pkg::RATE_IN_W-1]) r.status = drtf_pkg::ST_NEG;
        else if (dates.size() >= drtf_pkg::TABLE_DEPTH) r.status = drtf_pkg::ST_FULL;
        else begin
          dates.insert(pos, key);
          rates.insert(pos, rate_in[drtf_pkg::RATE_W-1:0]);
          r.date = key;
          r.rate = rate_in[drtf_pkg::RATE_W-1:0];
        end
      end else if (amt[drtf_pkg::AMT_W-1] || amt > drtf_pkg::AMOUNT_LIMIT) begin
        r.status = drtf_pkg::ST_RANGE;
      end else if (hit || pos > 0) begin
        idx      = hit ? pos : pos - 1;
        r.status = hit ? drtf_pkg::ST_EXACT : drtf_pkg::ST_EARLIER;
        r.date   = dates[idx];
        r.rate   = rates[idx];
        prod     = {47'b0, amt[drtf_pkg::MUL_A_W-1:0]} * {26'b0, rates[idx]};
        r.value  = prod[72:16];
      end else begin
        r.status = drtf_pkg::ST_NONE;
      end
      pending_replies.push_back(r);
      words_logged++;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 200) $display("MISMATCH at reply %0d: %s", replies_seen, what);
    endtask

    task check_reply(logic [2:0] st, logic [drtf_pkg::DATE_W-1:0] d,
                     logic [drtf_pkg::RATE_W-1:0] r, logic [drtf_pkg::VALUE_W-1:0] v);
      rate_reply_t e;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected word, status %0d date %0d", st, d));
        return;
      end
      e = pending_replies.pop_front();
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, wanted %0d", st, e.status));
      if (d !== e.date)
        report_mismatch($sformatf("date_used %0d, wanted %0d", d, e.date));
      if (r !== e.rate)
        report_mismatch($sformatf("rate_used %h, wanted %h", r, e.rate));
      if (v !== e.value)
        report_mismatch($sformatf("value %h, wanted %h", v, e.value));
      status_seen[int'(e.status)]++;
      replies_seen++;
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic [2:0]   out_tuser;

  rate_table_model sb = new();
  int burst_left;
  int holdoff_req;
  int cycle_count;

  dated_rate_table_floor_convert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count,
               sb.pending_replies.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_reply(out_tuser, out_tdata[22:0], out_tdata[69:23], out_tdata[126:70]);
  end

  // receiver: stall pattern of its own, plus long hold-offs on request
  initial begin
    int holdoff_seen, mode, mode_left;
    holdoff_seen = 0;
    mode         = 0;
    mode_left    = 0;
    out_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  task automatic drive_word(bit act, bit [drtf_pkg::DATE_W-1:0] key,
                            bit [drtf_pkg::RATE_IN_W-1:0] rate_in,
                            bit [drtf_pkg::AMT_W-1:0] amt);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, amt, rate_in, key};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.log_request(act, key, rate_in, amt);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tuser  <= 1'($urandom_range(0, 1));
    in_tdata  <= {8'h00, $urandom, $urandom, $urandom};
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk);
  endtask

  // bursts of random length; some bursts follow straight on with no gap
  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  function automatic bit [drtf_pkg::DATE_W-1:0] calendar_date();
    return drtf_pkg::DATE_W'($urandom_range(2000, 2015) * 512 + $urandom_range(1, 12) * 32 +
                             $urandom_range(1, 31));
  endfunction

  function automatic bit [drtf_pkg::RATE_IN_W-1:0] random_rate();
    bit [63:0] w;
    int        pick;
    w    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 10) return {1'b1, w[46:0]};
    if (pick < 15) return '0;
    if (pick < 20) return RATE_MAX;
    if (pick < 60) return {24'b0, w[23:0]};
    return {1'b0, w[46:0]};
  endfunction

  function automatic bit [drtf_pkg::AMT_W-1:0] random_amount();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return {1'b1, 31'($urandom)};
    if (pick < 8) return $urandom_range(drtf_pkg::AMOUNT_LIMIT + 1, 32'h7FFF_FFFF);
    if (pick < 10) return drtf_pkg::AMOUNT_LIMIT + 1;
    if (pick < 15) return '0;
    if (pick < 20) return drtf_pkg::AMOUNT_LIMIT;
    return $urandom_range(0, drtf_pkg::AMOUNT_LIMIT);
  endfunction

  task automatic send_random(int insert_pct);
    bit [drtf_pkg::DATE_W-1:0] key;
    int                        pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < insert_pct) begin
      if (pick < 15) key = sb.known_date();
      else if (pick < 75) key = calendar_date();
      else key = drtf_pkg::DATE_W'($urandom_range(0, FILL_BASE - 1));
      drive_word(1'b0, key, random_rate(), random_amount());
    end else begin
      if (pick < 40) key = sb.known_date();
      else if (pick < 55) key = sb.known_date() + drtf_pkg::DATE_W'($urandom_range(1, 40));
      else if (pick < 85) key = calendar_date();
      else key = drtf_pkg::DATE_W'($urandom);
      drive_word(1'b1, key, random_rate(), random_amount());
    end
  endtask

  initial begin
    int          n_fill;
    int unsigned fill_key;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    burst_left  = 0;
    holdoff_req = 0;
    cycle_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table, edge amounts, ordering of the insert rejections
    drive_word(1'b1, 23'd1031215, '0, 32'd0);
    drive_word(1'b1, 23'd1031215, '0, 32'h8000_0000);
    drive_word(1'b0, 23'd1031215, 48'h1_8000, '0);
    drive_word(1'b1, 23'd1000, '0, 32'h0001_0000);
    drive_word(1'b0, 23'd0, '0, '0);
    drive_word(1'b0, 23'h7FFFFF, RATE_MAX, 32'hFFFF_FFFF);
    drive_word(1'b0, 23'd0, RATE_ONE, '0);
    drive_word(1'b0, 23'd0, 48'h8000_0000_0000, '0);
    drive_word(1'b0, 23'd100, 48'h8000_0000_0000, '0);
    drive_word(1'b0, 23'd100, 48'hFFFF_FFFF_FFFF, '0);
    drive_word(1'b0, 23'd5, RATE_ONE, '0);
    drive_word(1'b1, 23'd1031215, '0, drtf_pkg::AMOUNT_LIMIT);
    drive_word(1'b1, 23'd1031216, '0, drtf_pkg::AMOUNT_LIMIT + 1);
    drive_word(1'b1, 23'd1031216, '0, 32'h7FFF_FFFF);
    drive_word(1'b1, 23'd1031216, '0, 32'd12345);
    drive_word(1'b1, 23'h7FFFFF, '0, drtf_pkg::AMOUNT_LIMIT);
    drive_word(1'b1, 23'h7FFFFE, '0, 32'h0001_0000);
    drive_word(1'b1, 23'd0, '0, 32'h0001_0000);
    drive_word(1'b1, 23'd4, '0, 32'h0003_8000);
    drive_word(1'b1, 23'd0, '0, 32'hFFFF_FFFF);
    wait_drained();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 340 == 170) begin
        // block the output for a long stretch while words keep coming
        holdoff_req++;
        repeat (12) send_random(40);
      end
      if (i % 340 == 339) wait_drained();
      pace();
      send_random(25 + (i / 340) * 8);
    end

    // fill the table in ascending order above everything stored so far
    wait_drained();
    n_fill   = drtf_pkg::TABLE_DEPTH - sb.dates.size();
    fill_key = FILL_BASE;
    while (n_fill > 0) begin
      pace();
      if ($urandom_range(0, 7) == 0) begin
        send_random(0);
      end else begin
        fill_key += $urandom_range(1, 40);
        drive_word(1'b0, drtf_pkg::DATE_W'(fill_key), {1'b0, 47'($urandom)}, '0);
        n_fill--;
      end
    end

    // full table: duplicate and negative rate still win over full
    drive_word(1'b0, drtf_pkg::DATE_W'(fill_key + 1), RATE_ONE, '0);
    drive_word(1'b0, drtf_pkg::DATE_W'(fill_key), RATE_ONE, '0);
    drive_word(1'b0, drtf_pkg::DATE_W'(fill_key + 2), 48'h8000_0000_0001, '0);
    drive_word(1'b1, drtf_pkg::DATE_W'(fill_key + 3), '0, drtf_pkg::AMOUNT_LIMIT);
    for (int i = 0; i < 40; i++) begin
      pace();
      send_random(15);
    end

    wait_drained();
    repeat (60) @(posedge clk);
    $display("Checked %0d replies over %0d words; table ended with %0d entries",
             sb.replies_seen, sb.words_logged, sb.dates.size());
    $display("stored %0d exact %0d earlier %0d none %0d dup %0d neg %0d full %0d range %0d",
             sb.status_seen[drtf_pkg::ST_STORED], sb.status_seen[drtf_pkg::ST_EXACT],
             sb.status_seen[drtf_pkg::ST_EARLIER], sb.status_seen[drtf_pkg::ST_NONE],
             sb.status_seen[drtf_pkg::ST_DUP], sb.status_seen[drtf_pkg::ST_NEG],
             sb.status_seen[drtf_pkg::ST_FULL], sb.status_seen[drtf_pkg::ST_RANGE]);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
